[hdl/euq_pkg.sv]
// euler to quaternion package: item types and cordic constants
package euq_pkg;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   localparam int MAX_STEPS = 20;
   localparam int NUM_ANGLES = 3;
   localparam int ROLL = 0;
   localparam int PITCH = 1;
   localparam int YAW = 2;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [20:0] Q14_ONE = 21'sd16384;

   // atan(2^-i) in q30
   localparam logic signed [33:0] ATAN_Q30 [MAX_STEPS] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
      34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
      34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
      34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047
   };

endpackage

[hdl/euler_to_quaternion_unit.sv]
// euler to quaternion unit: pipelined cordic half-angle sin/cos and zyx products
//
// Converts roll, pitch and yaw (signed Q2.13 radians) into a unit quaternion
// in ZYX order, each component signed Q1.14 saturated to +-1.
// Input channel: an item is taken at a clock edge with start high and busy
// low. busy is always low: the pipeline takes one item every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_data; the
// receiver cannot hold results off and the pipeline never stalls.
// Stages: one for range folding, one per cordic micro-rotation, then
// rounding, pairwise products, triple products and the final
// sum/saturate; the result strobe comes from the last of them.
// Throughput: one item per cycle, set by the fully unrolled cordic stages
// that run the three angles side by side.
// Reset: synchronous, clears the valid bits only; items in flight are
// dropped and no result appears until a new item has gone through.
module euler_to_quaternion_unit #(
   parameter int TRIG_ITERATIONS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  euq_pkg::req_type  req_data,
   output logic              rsp_valid,
   output euq_pkg::rsp_type  rsp_data
);

   localparam int STEPS = (TRIG_ITERATIONS > euq_pkg::MAX_STEPS) ?
                          euq_pkg::MAX_STEPS : TRIG_ITERATIONS;
   localparam int NA = euq_pkg::NUM_ANGLES;

   // cordic pipeline
   logic               v_ff    [0:STEPS];
   logic signed [33:0] x_ff    [0:STEPS][NA];
   logic signed [33:0] y_ff    [0:STEPS][NA];
   logic signed [33:0] z_ff    [0:STEPS][NA];
   logic               flip_ff [0:STEPS][NA];
   logic signed [33:0] x_in    [0:STEPS][NA];
   logic signed [33:0] y_in    [0:STEPS][NA];
   logic signed [33:0] z_in    [0:STEPS][NA];
   logic               flip_in [0:STEPS][NA];
   logic signed [15:0] ang     [NA];

   // rounded sin/cos, q15
   logic               rv_ff;
   logic signed [16:0] s_ff [NA];
   logic signed [16:0] c_ff [NA];
   logic signed [16:0] s_in [NA];
   logic signed [16:0] c_in [NA];

   // pairwise products
   logic               pv_ff;
   logic signed [33:0] cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [16:0] cy_ff, sy_ff;
   logic signed [33:0] cc_in, ss_in, sc_in, cs_in;

   // triple products, q45
   logic               tv_ff;
   logic signed [50:0] t_ff [8];
   logic signed [50:0] t_in [8];

   logic               ov_ff;
   euq_pkg::rsp_type   out_ff;
   euq_pkg::rsp_type   out_in;

   assign busy = 1'b0;
   assign ang[euq_pkg::ROLL]  = req_data.roll_angle;
   assign ang[euq_pkg::PITCH] = req_data.pitch_angle;
   assign ang[euq_pkg::YAW]   = req_data.yaw_angle;

   // fold half angle into +-pi/2, remember to negate later
   always_comb begin
      logic signed [33:0] z0;
      for (int a = 0; a < NA; a++) begin
         z0 = {{2{ang[a][15]}}, ang[a], 16'b0};
         x_in[0][a] = euq_pkg::CORDIC_GAIN;
         y_in[0][a] = '0;
         if (z0 > euq_pkg::HALF_PI_Q30) begin
            z_in[0][a] = z0 - euq_pkg::PI_Q30;
            flip_in[0][a] = 1'b1;
         end else if (z0 < -euq_pkg::HALF_PI_Q30) begin
            z_in[0][a] = z0 + euq_pkg::PI_Q30;
            flip_in[0][a] = 1'b1;
         end else begin
            z_in[0][a] = z0;
            flip_in[0][a] = 1'b0;
         end
      end

      // one micro-rotation per stage
      for (int s = 0; s < STEPS; s++) begin
         for (int a = 0; a < NA; a++) begin
            flip_in[s+1][a] = flip_ff[s][a];
            if (!z_ff[s][a][33]) begin
               x_in[s+1][a] = x_ff[s][a] - (y_ff[s][a] >>> s);
               y_in[s+1][a] = y_ff[s][a] + (x_ff[s][a] >>> s);
               z_in[s+1][a] = z_ff[s][a] - euq_pkg::ATAN_Q30[s];
            end else begin
               x_in[s+1][a] = x_ff[s][a] + (y_ff[s][a] >>> s);
               y_in[s+1][a] = y_ff[s][a] - (x_ff[s][a] >>> s);
               z_in[s+1][a] = z_ff[s][a] + euq_pkg::ATAN_Q30[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= STEPS; s++) begin
         for (int a = 0; a < NA; a++) begin
            x_ff[s][a]    <= x_in[s][a];
            y_ff[s][a]    <= y_in[s][a];
            z_ff[s][a]    <= z_in[s][a];
            flip_ff[s][a] <= flip_in[s][a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else begin
         v_ff[0] <= start;
         for (int s = 0; s < STEPS; s++) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
   end

   // negate if folded, round q30 to q15
   always_comb begin
      logic signed [33:0] xf, yf, xr, yr;
      for (int a = 0; a < NA; a++) begin
         xf = flip_ff[STEPS][a] ? -x_ff[STEPS][a] : x_ff[STEPS][a];
         yf = flip_ff[STEPS][a] ? -y_ff[STEPS][a] : y_ff[STEPS][a];
         xr = (xf + 34'sd16384) >>> 15;
         yr = (yf + 34'sd16384) >>> 15;
         c_in[a] = xr[16:0];
         s_in[a] = yr[16:0];
      end
   end

   always_comb begin
      cc_in = c_ff[euq_pkg::ROLL] * c_ff[euq_pkg::PITCH];
      ss_in = s_ff[euq_pkg::ROLL] * s_ff[euq_pkg::PITCH];
      sc_in = s_ff[euq_pkg::ROLL] * c_ff[euq_pkg::PITCH];
      cs_in = c_ff[euq_pkg::ROLL] * s_ff[euq_pkg::PITCH];
   end

   always_comb begin
      t_in[0] = cc_ff * cy_ff;
      t_in[1] = ss_ff * sy_ff;
      t_in[2] = sc_ff * cy_ff;
      t_in[3] = cs_ff * sy_ff;
      t_in[4] = cs_ff * cy_ff;
      t_in[5] = sc_ff * sy_ff;
      t_in[6] = cc_ff * sy_ff;
      t_in[7] = ss_ff * cy_ff;
   end

   function automatic logic signed [15:0] to_q14(input logic signed [51:0] q45);
      logic signed [51:0] r;
      logic signed [20:0] v;
      r = (q45 + 52'sd1073741824) >>> 31;
      v = r[20:0];
      if (v > euq_pkg::Q14_ONE) begin
         v = euq_pkg::Q14_ONE;
      end else if (v < -euq_pkg::Q14_ONE) begin
         v = -euq_pkg::Q14_ONE;
      end
      return v[15:0];
   endfunction

   always_comb begin
      out_in.quat_w = to_q14(52'(t_ff[0]) + 52'(t_ff[1]));
      out_in.quat_x = to_q14(52'(t_ff[2]) - 52'(t_ff[3]));
      out_in.quat_y = to_q14(52'(t_ff[4]) + 52'(t_ff[5]));
      out_in.quat_z = to_q14(52'(t_ff[6]) - 52'(t_ff[7]));
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < NA; a++) begin
         s_ff[a] <= s_in[a];
         c_ff[a] <= c_in[a];
      end
      cc_ff <= cc_in;
      ss_ff <= ss_in;
      sc_ff <= sc_in;
      cs_ff <= cs_in;
      cy_ff <= c_ff[euq_pkg::YAW];
      sy_ff <= s_ff[euq_pkg::YAW];
      for (int k = 0; k < 8; k++) begin
         t_ff[k] <= t_in[k];
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
         tv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         rv_ff <= v_ff[STEPS];
         pv_ff <= rv_ff;
         tv_ff <= pv_ff;
         ov_ff <= tv_ff;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

endmodule

[sim/euq_checker.sv]
// euler to quaternion checker: watches both channels, predicts each quaternion and compares
`timescale 1ns / 100ps
module euq_checker #(
   parameter int TRIG_ITERATIONS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  euq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  euq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_quats
);

   euq_pkg::rsp_type quat_queue [$];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // sine and cosine of half the angle, both q15
   function automatic void half_angle_trig(input logic signed [15:0] angle,
                                           output longint s_q15,
                                           output longint c_q15);
      longint z, x, y, dx, dy;
      bit flip;
      int steps;
      z = longint'(angle) * 65536;
      x = longint'(euq_pkg::CORDIC_GAIN);
      y = 0;
      flip = 0;
      steps = (TRIG_ITERATIONS > euq_pkg::MAX_STEPS) ? euq_pkg::MAX_STEPS
                                                      : TRIG_ITERATIONS;
      if (z > longint'(euq_pkg::HALF_PI_Q30)) begin
         z = z - longint'(euq_pkg::PI_Q30);
         flip = 1;
      end else if (z < -longint'(euq_pkg::HALF_PI_Q30)) begin
         z = z + longint'(euq_pkg::PI_Q30);
         flip = 1;
      end
      for (int i = 0; i < steps; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(euq_pkg::ATAN_Q30[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(euq_pkg::ATAN_Q30[i]);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c_q15 = floor_shift(x + 16384, 15);
      s_q15 = floor_shift(y + 16384, 15);
   endfunction

   function automatic logic signed [15:0] round_sat_q14(longint q45);
      longint v;
      v = floor_shift(q45 + (64'sd1 <<< 30), 31);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   function automatic euq_pkg::rsp_type predict_quat(euq_pkg::req_type item);
      longint sr, cr, sp, cp, sy, cy;
      euq_pkg::rsp_type q;
      half_angle_trig(item.roll_angle, sr, cr);
      half_angle_trig(item.pitch_angle, sp, cp);
      half_angle_trig(item.yaw_angle, sy, cy);
      q.quat_w = round_sat_q14(cr * cp * cy + sr * sp * sy);
      q.quat_x = round_sat_q14(sr * cp * cy - cr * sp * sy);
      q.quat_y = round_sat_q14(cr * sp * cy + sr * cp * sy);
      q.quat_z = round_sat_q14(cr * cp * sy - sr * sp * cy);
      return q;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_quats = 0;
   end

   always @(posedge clock) begin
      euq_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (quat_queue.size() == 0) begin
               report_mismatch("result with no item waiting");
            end else begin
               want = quat_queue.pop_front();
               if (rsp_data.quat_w !== want.quat_w)
                  report_mismatch($sformatf("quat_w %0d want %0d",
                                            rsp_data.quat_w, want.quat_w));
               if (rsp_data.quat_x !== want.quat_x)
                  report_mismatch($sformatf("quat_x %0d want %0d",
                                            rsp_data.quat_x, want.quat_x));
               if (rsp_data.quat_y !== want.quat_y)
                  report_mismatch($sformatf("quat_y %0d want %0d",
                                            rsp_data.quat_y, want.quat_y));
               if (rsp_data.quat_z !== want.quat_z)
                  report_mismatch($sformatf("quat_z %0d want %0d",
                                            rsp_data.quat_z, want.quat_z));
            end
         end
         if (start && !busy) quat_queue.push_back(predict_quat(req_data));
         pending_quats = quat_queue.size();
      end
   end
endmodule

[sim/tb_euler_to_quaternion_unit.sv]
// euler to quaternion testbench top: stimulus, clock, reset and verdict
`timescale 1ns / 100ps
module tb_euler_to_quaternion_unit;

   localparam int TRIG_ITERATIONS = 14;
   localparam int LATENCY = TRIG_ITERATIONS + 6;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   euq_pkg::req_type req_data = '0;
   logic rsp_valid;
   euq_pkg::rsp_type rsp_data;
   int fail_count, pending_quats;
   int cycle_count = 0;
   int idle_pct = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   euler_to_quaternion_unit #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data));

   euq_checker #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_quats(pending_quats));

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("euler_to_quaternion_unit verification failed");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(16'(12868 + $urandom_range(0, 4)) *
                       ($urandom_range(0, 1) ? 1 : -1));
         default: return 16'($urandom);
      endcase
   endfunction

   // presents one item, holding start across back-to-back items
   task automatic send_item(input euq_pkg::req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   localparam logic signed [15:0] DIRECTED [12] = '{
      16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sd12868,
      16'sd12869, -16'sd12868, -16'sd12869, 16'sd6434, 16'sh5555, 16'shaaaa};

   initial begin
      euq_pkg::req_type item;
      repeat (3) @(posedge clock);
      reset <= 0;
      for (int i = 0; i < 12; i++) begin
         item.roll_angle = DIRECTED[i];
         item.pitch_angle = DIRECTED[(i + 4) % 12];
         item.yaw_angle = DIRECTED[(i + 8) % 12];
         send_item(item);
      end
      for (int i = 0; i < 8; i++) begin
         item.roll_angle = DIRECTED[i];
         item.pitch_angle = DIRECTED[i];
         item.yaw_angle = DIRECTED[i];
         send_item(item);
      end
      // the receiver cannot stall, so the phases vary only how often the sender idles
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 88 : (phase == 3) ? 36 : 0;
         for (int i = 0; i < 335; i++) begin
            item.roll_angle = pick_angle();
            item.pitch_angle = pick_angle();
            item.yaw_angle = pick_angle();
            send_item(item);
         end
      end
      start <= 0;
      @(posedge clock);
      while (pending_quats != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0) begin
         $display("euler_to_quaternion_unit verification clean");
      end else begin
         $display("euler_to_quaternion_unit verification failed");
      end
      $finish;
   end
endmodule

[euler_to_quaternion_unit.f]
hdl/euq_pkg.sv
hdl/euler_to_quaternion_unit.sv
sim/euq_checker.sv
sim/tb_euler_to_quaternion_unit.sv
